FILE: rtl/core/crc16_dfr_pkg.sv
// ----------------------------------------------------------------------------
// crc16_dfr_pkg
// Shared types, constants and the CRC-16/MCRF4XX byte update for the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16_dfr_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 2'd1;

    localparam logic [7:0]  START_MARKER_RST = 8'hA1;
    localparam logic [7:0]  MAX_LENGTH_RST   = 8'd200;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;

    // deframer phase, one-hot
    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_TYPE    = 5'b00010,
        PH_LENGTH  = 5'b00100,
        PH_CRC     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic [7:0] packet_type;
        logic [7:0] payload_length;
        logic       has_data;
        logic       is_last;
        logic       crc_ok;
    } res_t;

    // reflected 0x8408 update, one byte, table-free form
    function automatic logic [15:0] crc_step(input logic [7:0] b, input logic [15:0] crc);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        crc_step = {t, crc[15:8]} ^ {12'h000, t[7:4]} ^ {5'b00000, t, 3'b000};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/crc16_packet_deframer_top.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_top
// Start-byte / length framed packet deframer with CRC-16/MCRF4XX check.
// ----------------------------------------------------------------------------
// A result is on the output in the cycle after its byte's transfer.
// Throughput: one byte per cycle while in_ready is high; the state machine
//   and byte-wide CRC update sit between the state and result registers.
// in_ready drops only while a held result is not taken by downstream.
// Reset (rst_n, async, active low): hunting, CRC 0xFFFF, output empty,
//   start_marker 0xA1, max_length 200.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_deframer_top
    import crc16_dfr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    // byte input
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           data_byte,
    // result output
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                payload_byte,
    output logic [7:0]                packet_type,
    output logic [7:0]                payload_length,
    output logic                      has_data,
    output logic                      is_last,
    output logic                      crc_ok
);

    logic [7:0] start_marker_reg, start_marker_next;
    logic [7:0] max_length_reg,   max_length_next;

    logic step;
    logic res_valid;
    res_t res;
    res_t out_res;
    logic load_ok;

    // config writes are always taken; values apply from the next byte on
    assign cfg_ready = 1'b1;

    always_comb
    begin
        start_marker_next = start_marker_reg;
        max_length_next   = max_length_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_next = cfg_data;
                CFG_MAX_LENGTH:   max_length_next   = cfg_data;
                default:          ; // unknown index: write ignored
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            max_length_reg   <= MAX_LENGTH_RST;
        end
        else
        begin
            start_marker_reg <= start_marker_next;
            max_length_reg   <= max_length_next;
        end
    end

    // a byte moves whenever the result register can take what it produces
    assign in_ready = load_ok;
    assign step     = in_valid && in_ready;

    crc16_dfr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .data_byte    (data_byte),
        .start_marker (start_marker_reg),
        .max_length   (max_length_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    crc16_dfr_oreg u_oreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .load_ok   (load_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign payload_byte   = out_res.payload_byte;
    assign packet_type    = out_res.packet_type;
    assign payload_length = out_res.payload_length;
    assign has_data       = out_res.has_data;
    assign is_last        = out_res.is_last;
    assign crc_ok         = out_res.crc_ok;

endmodule

`default_nettype wire

FILE: rtl/core/crc16_dfr_core.sv
// ----------------------------------------------------------------------------
// crc16_dfr_core
// Framing state machine and running CRC; one byte per step, result is comb.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_dfr_core
    import crc16_dfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] data_byte,
    input  wire logic [7:0] start_marker,
    input  wire logic [7:0] max_length,
    output logic            res_valid,
    output res_t            res
);

    phase_t      phase_reg,      phase_next;
    logic [15:0] crc_reg,        crc_next;
    logic [7:0]  rx_lo_reg,      rx_lo_next;
    logic [7:0]  rx_hi_reg,      rx_hi_next;
    logic        crc_idx_reg,    crc_idx_next;
    logic [7:0]  type_reg,       type_next;
    logic [7:0]  length_reg,     length_next;
    logic [7:0]  seen_reg,       seen_next;

    logic [15:0] crc_upd;
    logic [15:0] crc_src;
    logic [7:0]  seen_inc;

    assign crc_src  = (phase_reg == PH_TYPE) ? CRC_INIT : crc_reg;
    assign crc_upd  = crc_step(data_byte, crc_src);
    assign seen_inc = seen_reg + 8'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        crc_next     = crc_reg;
        rx_lo_next   = rx_lo_reg;
        crc_idx_next = crc_idx_reg;
        type_next    = type_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        res_valid    = 1'b0;
        res.payload_byte   = data_byte;
        res.packet_type    = type_reg;
        res.payload_length = length_reg;
        res.has_data       = 1'b1;
        res.is_last        = 1'b0;
        res.crc_ok         = 1'b0;

        if (step)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (data_byte == start_marker)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next    = data_byte;
                    length_next  = 8'd0;
                    seen_next    = 8'd0;
                    rx_lo_next   = 8'd0;
                    crc_idx_next = 1'b0;
                    crc_next     = crc_upd;
                    phase_next   = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    if (data_byte > max_length)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        length_next  = data_byte;
                        crc_next     = crc_upd;
                        crc_idx_next = 1'b0;
                        phase_next   = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    if (!crc_idx_reg)
                    begin
                        rx_lo_next   = data_byte;
                        crc_idx_next = 1'b1;
                    end
                    else
                    begin
                        crc_idx_next = 1'b0;
                        if (length_reg == 8'd0)
                        begin
                            // empty packet: one result carrying only the verdict
                            res_valid        = 1'b1;
                            res.payload_byte = 8'd0;
                            res.has_data     = 1'b0;
                            res.is_last      = 1'b1;
                            res.crc_ok       = ({data_byte, rx_lo_reg} == crc_reg);
                            phase_next       = PH_HUNT;
                        end
                        else
                        begin
                            rx_lo_next = rx_lo_reg;
                            seen_next  = 8'd0;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next  = crc_upd;
                    seen_next = seen_inc;
                    res_valid = 1'b1;
                    if (seen_inc == length_reg)
                    begin
                        res.is_last = 1'b1;
                        res.crc_ok  = ({rx_hi_reg, rx_lo_reg} == crc_upd);
                        phase_next  = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // high CRC byte is kept once the second CRC byte arrives
    assign rx_hi_next = (step && phase_reg == PH_CRC && crc_idx_reg) ? data_byte : rx_hi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            crc_reg     <= CRC_INIT;
            rx_lo_reg   <= 8'd0;
            rx_hi_reg   <= 8'd0;
            crc_idx_reg <= 1'b0;
            type_reg    <= 8'd0;
            length_reg  <= 8'd0;
            seen_reg    <= 8'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            crc_reg     <= crc_next;
            rx_lo_reg   <= rx_lo_next;
            rx_hi_reg   <= rx_hi_next;
            crc_idx_reg <= crc_idx_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
        end
    end

    a_hunt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT || phase_reg == PH_TYPE || phase_reg == PH_LENGTH) |-> !res_valid)
        else $error("result produced outside CRC/payload phase");

    a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.is_last) |=> phase_reg == PH_HUNT)
        else $error("last result did not return to hunting");

    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> (seen_reg < length_reg))
        else $error("payload byte count overran declared length");

    a_ok_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.crc_ok) |-> res.is_last)
        else $error("crc_ok set on a non-final result");

endmodule

`default_nettype wire

FILE: rtl/core/crc16_dfr_oreg.sv
// ----------------------------------------------------------------------------
// crc16_dfr_oreg
// Result register; holds a result until downstream takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_dfr_oreg
    import crc16_dfr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic res_valid,
    input  wire res_t res,
    output logic      load_ok,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      out_res
);

    logic valid_reg, valid_next;
    res_t data_reg;

    // free when empty or when the held result leaves this cycle
    assign load_ok    = !valid_reg || out_ready;
    assign valid_next = load_ok ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

`default_nettype wire

FILE: verif/crc16_packet_deframer_top_test.sv
// ----------------------------------------------------------------------------
// crc16_packet_deframer_top_test
// Self-checking bench for the streaming CRC-16 packet deframer.
// Drives framed byte streams with random sender gaps and receiver stalls.
// A local deframing model predicts every result. Results are checked field by
// field, in order, as each output transfer completes.
// ----------------------------------------------------------------------------

module crc16_packet_deframer_top_test;
    import crc16_dfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles with no transfer on any channel before the run is called hung.
    // The longest legal quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 80;
    // A result is registered after its byte; spare cycles cover header bytes
    // still in flight before a register write or the final verdict.
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 160;
    localparam int CFG_INTERVAL   = 60;

    typedef logic [7:0] byte_q_t[$];

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = CFG_START_MARKER;
    logic [7:0]           cfg_data       = 8'h00;
    logic                 in_valid       = 1'b0;
    logic                 in_ready;
    logic [7:0]           data_byte      = 8'h00;
    logic                 out_valid;
    logic                 out_ready      = 1'b0;
    logic [7:0]           payload_byte;
    logic [7:0]           packet_type;
    logic [7:0]           payload_length;
    logic                 has_data;
    logic                 is_last;
    logic                 crc_ok;

    // Deframing model state, updated on every accepted input byte
    logic [7:0]  cfg_start_marker;
    logic [7:0]  cfg_max_length;
    phase_t      dfr_phase;
    logic [15:0] dfr_crc;
    logic [15:0] dfr_rx_crc;
    logic        dfr_crc_hi;
    logic [7:0]  dfr_type;
    logic [7:0]  dfr_length;
    logic [7:0]  dfr_count;

    res_t pending_results[$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    bit tx_idle_on     = 1'b1;
    bit rx_idle_on     = 1'b1;
    bit rx_hold_req    = 1'b0;

    crc16_packet_deframer_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .payload_byte   (payload_byte),
        .packet_type    (packet_type),
        .payload_length (payload_length),
        .has_data       (has_data),
        .is_last        (is_last),
        .crc_ok         (crc_ok)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------

    // CRC-16/MCRF4XX, bit-serial: reflected poly 0x8408, no final xor
    function automatic logic [15:0] crc_mcrf(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    function automatic void reset_model();
        cfg_start_marker = START_MARKER_RST;
        cfg_max_length   = MAX_LENGTH_RST;
        dfr_phase        = PH_HUNT;
        dfr_crc          = CRC_INIT;
        dfr_rx_crc       = 16'h0000;
        dfr_crc_hi       = 1'b0;
        dfr_type         = 8'h00;
        dfr_length       = 8'h00;
        dfr_count        = 8'h00;
    endfunction

    function automatic void push_result(input logic [7:0] pb, input logic has,
                                        input logic last, input logic ok);
        res_t r;
        r.payload_byte   = pb;
        r.packet_type    = dfr_type;
        r.payload_length = dfr_length;
        r.has_data       = has;
        r.is_last        = last;
        r.crc_ok         = ok;
        pending_results.push_back(r);
    endfunction

    // Advance the model by one accepted byte; queue the result it causes
    function automatic void deframe_byte(input logic [7:0] b);
        case (dfr_phase)
            PH_HUNT:
            begin
                if (b == cfg_start_marker)
                    dfr_phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                dfr_type   = b;
                dfr_length = 8'h00;
                dfr_count  = 8'h00;
                dfr_rx_crc = 16'h0000;
                dfr_crc_hi = 1'b0;
                dfr_crc    = crc_mcrf(CRC_INIT, b);
                dfr_phase  = PH_LENGTH;
            end
            PH_LENGTH:
            begin
                // oversize length drops the frame; this byte is not a start
                if (b > cfg_max_length)
                    dfr_phase = PH_HUNT;
                else
                begin
                    dfr_length = b;
                    dfr_crc    = crc_mcrf(dfr_crc, b);
                    dfr_crc_hi = 1'b0;
                    dfr_phase  = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (!dfr_crc_hi)
                begin
                    dfr_rx_crc = {8'h00, b};
                    dfr_crc_hi = 1'b1;
                end
                else
                begin
                    dfr_rx_crc[15:8] = b;
                    dfr_crc_hi       = 1'b0;
                    if (dfr_length == 8'h00)
                    begin
                        push_result(8'h00, 1'b0, 1'b1, dfr_rx_crc == dfr_crc);
                        dfr_phase = PH_HUNT;
                    end
                    else
                    begin
                        dfr_count = 8'h00;
                        dfr_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                dfr_crc   = crc_mcrf(dfr_crc, b);
                dfr_count = dfr_count + 8'd1;
                if (dfr_count == dfr_length)
                begin
                    push_result(b, 1'b1, 1'b1, dfr_rx_crc == dfr_crc);
                    dfr_phase = PH_HUNT;
                end
                else
                    push_result(b, 1'b1, 1'b0, 1'b0);
            end
            default:
                dfr_phase = PH_HUNT;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic byte_q_t rand_body(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // One input transfer. Valid stays high afterwards so the next byte can
    // follow without a bubble; wait_idle() drops it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        deframe_byte(b);
    endtask

    // start, type, length, CRC low, CRC high, then the body bytes.
    // len_field may differ from body size to build oversize or odd frames.
    task automatic send_frame(input logic [7:0] typ, input byte_q_t body,
                              input logic [7:0] len_field, input bit bad_crc);
        logic [15:0] crc;
        crc = crc_mcrf(CRC_INIT, typ);
        crc = crc_mcrf(crc, len_field);
        foreach (body[i])
            crc = crc_mcrf(crc, body[i]);
        if (bad_crc)
            crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
        send_byte(cfg_start_marker);
        send_byte(typ);
        send_byte(len_field);
        send_byte(crc[7:0]);
        send_byte(crc[15:8]);
        foreach (body[i])
            send_byte(body[i]);
    endtask

    // Drop valid, let every expected result drain, then allow a header
    // byte's worth of processing to finish before touching registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers back to back; valid is held across the two transfers
    task automatic apply_config(input logic [7:0] marker, input logic [7:0] max_len);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_START_MARKER;
        cfg_data  <= marker;
        do @(posedge clk); while (!cfg_ready);
        cfg_start_marker = marker;
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= max_len;
        do @(posedge clk); while (!cfg_ready);
        cfg_max_length = max_len;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else
            begin
                n = rx_idle_on ? pick_gap() : 0;
                if (n == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (n - 1) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, payload_byte", payload_byte, 0);
            else
            begin
                want = pending_results.pop_front();
                if (payload_byte !== want.payload_byte)
                    report_mismatch("payload_byte", payload_byte, want.payload_byte);
                if (packet_type !== want.packet_type)
                    report_mismatch("packet_type", packet_type, want.packet_type);
                if (payload_length !== want.payload_length)
                    report_mismatch("payload_length", payload_length, want.payload_length);
                if (has_data !== want.has_data)
                    report_mismatch("has_data", has_data, want.has_data);
                if (is_last !== want.is_last)
                    report_mismatch("is_last", is_last, want.is_last);
                if (crc_ok !== want.crc_ok)
                    report_mismatch("crc_ok", crc_ok, want.crc_ok);
            end
        end
    end

    // Hang detector: any transfer on any channel resets the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR %0t ns: no transfer for %0d cycles", $time, idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values: empty frames, one-byte frame at the extremes,
    // bad CRC, oversize length, start byte inside the payload
    task automatic test_reset_defaults();
        byte_q_t no_payload;
        byte_q_t body;
        send_frame(8'h00, no_payload, 8'd0, 1'b0);
        body = {8'hFF};
        send_frame(8'hFF, body, 8'd1, 1'b0);
        send_frame(8'h42, no_payload, 8'd0, 1'b1);
        // length one above the reset limit aborts; hunting resumes
        send_byte(START_MARKER_RST);
        send_byte(8'h17);
        send_byte(8'(MAX_LENGTH_RST + 8'd1));
        body = {START_MARKER_RST, 8'h00};
        send_frame(8'h81, body, 8'd2, 1'b0);
        wait_idle();
    endtask

    // Register extremes: zero limit, oversize length equal to the marker,
    // then the largest length the limit allows
    task automatic test_register_extremes();
        byte_q_t no_payload;
        byte_q_t body;
        apply_config(8'h00, 8'd0);
        body = rand_body(1);
        send_frame(8'h99, body, 8'd1, 1'b0);
        send_byte(8'h55);
        send_frame(8'h66, no_payload, 8'd0, 1'b0);
        wait_idle();

        apply_config(8'hFF, 8'd0);
        // the aborting length byte matches the marker but must not reopen
        send_byte(8'hFF);
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_frame(8'h00, no_payload, 8'd0, 1'b0);
        wait_idle();

        apply_config(8'hFF, 8'd255);
        body = rand_body(255);
        send_frame(8'hC3, body, 8'd255, 1'b0);
        wait_idle();
    endtask

    // Receiver holds off while the sender streams: the result register
    // fills and in_ready must drop until the hold ends
    task automatic test_output_backpressure();
        byte_q_t body;
        apply_config(START_MARKER_RST, MAX_LENGTH_RST);
        tx_idle_on  = 1'b0;
        rx_hold_req = 1'b1;
        repeat (3)
        begin
            body = rand_body(8);
            send_frame(8'($urandom_range(0, 255)), body, 8'd8, 1'b0);
        end
        wait_idle();
        tx_idle_on = 1'b1;
    endtask

    // Full rate on both sides
    task automatic test_back_to_back();
        byte_q_t body;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (4)
        begin
            body = rand_body($urandom_range(0, 6));
            send_frame(8'($urandom_range(0, 255)), body, 8'(body.size()), $urandom_range(0, 3) == 0);
        end
        wait_idle();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Mostly well-formed frames with random content under changing
    // settings, mixed with oversize lengths, line noise and cut-off frames
    task automatic test_random_traffic();
        int          framed;
        int          next_cfg;
        int          kind;
        int          cap;
        int          len;
        int          r;
        logic [7:0]  max_len;
        byte_q_t     body;
        framed   = 0;
        next_cfg = 0;
        while (framed < RANDOM_ITEMS)
        begin
            if (framed >= next_cfg)
            begin
                wait_idle();
                r = $urandom_range(0, 99);
                if (r < 15)
                    max_len = 8'd0;
                else if (r < 30)
                    max_len = 8'd255;
                else
                    max_len = 8'($urandom_range(1, 40));
                apply_config(8'($urandom_range(0, 255)), max_len);
                next_cfg += CFG_INTERVAL;
            end
            cap  = (cfg_max_length < 12) ? cfg_max_length : 12;
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                if (cfg_max_length <= 40 && $urandom_range(0, 9) == 0)
                    len = cfg_max_length;
                else
                    len = $urandom_range(0, cap);
                body = rand_body(len);
                send_frame(8'($urandom_range(0, 255)), body, 8'(len), $urandom_range(0, 4) == 0);
                framed += 5 + len;
            end
            else if (kind < 80 && cfg_max_length < 255)
            begin
                body = rand_body($urandom_range(0, 3));
                send_frame(8'($urandom_range(0, 255)), body,
                           8'($urandom_range(cfg_max_length + 1, 255)), 1'b0);
                framed += 3;
            end
            else if (kind < 90)
            begin
                repeat ($urandom_range(1, 6))
                    send_byte(($urandom_range(0, 4) == 0) ? cfg_start_marker
                                                          : 8'($urandom_range(0, 255)));
            end
            else
            begin
                // frame cut short; following bytes land in its later fields
                send_byte(cfg_start_marker);
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                begin
                    send_byte(8'($urandom_range(0, cap)));
                    send_byte(8'($urandom_range(0, 255)));
                end
                framed += 2;
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_output_backpressure();
        test_back_to_back();
        test_random_traffic();

        // stray results after the last expected one still get caught
        wait_idle();

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/crc16_dfr_pkg.sv
rtl/core/crc16_dfr_core.sv
rtl/core/crc16_dfr_oreg.sv
rtl/core/crc16_packet_deframer_top.sv
verif/crc16_packet_deframer_top_test.sv
